>>> hdl/csef_pkg.sv
// Shared types, widths and constants of the CAN speed EMA filter.
`default_nettype none
package csef_pkg;

    // Field widths of the input word, the result word and the registers
    localparam int RAW_W       = 16;
    localparam int ID_W        = 29;
    localparam int LEN_W       = 4;
    localparam int BYTE_W      = 8;
    localparam int SPEED_W     = 10;
    localparam int AVG_W       = 24;
    localparam int IDLE_W      = 16;
    localparam int ALPHA_REG_W = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 29;

    // Fixed-point format of the average and of the smoothing weight
    localparam int AVG_FRAC_BITS = 8;
    localparam int ALPHA_BITS    = 16;

    // Hundredths to average format: ((raw << frac) + 50) / 100
    localparam int RAW_SCALE   = 100;
    localparam int RAW_ROUND   = 50;
    localparam int RAWX_W      = RAW_W + AVG_FRAC_BITS + 1;
    localparam int RAWFX_W     = RAWX_W - 6;
    localparam int RECIP_SHIFT = RAWX_W + 7;
    localparam int RECIP_W     = RECIP_SHIFT - 6;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(RAW_SCALE - 1)) / 64'(RAW_SCALE);
    localparam logic [RECIP_W-1:0] RECIP_MUL = RECIP_FULL[RECIP_W-1:0];

    // Blend datapath widths
    localparam int A_W    = ALPHA_BITS + 1;
    localparam int MAG_W  = (AVG_W > RAWFX_W) ? AVG_W : RAWFX_W;
    localparam int DIFF_W = MAG_W + 1;
    localparam int PROD_W = A_W + 1 + DIFF_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int Q_W    = SUM_W - ALPHA_BITS;
    localparam logic [A_W-1:0] ALPHA_ONE  = A_W'(1) << ALPHA_BITS;
    localparam logic [A_W-1:0] ALPHA_HALF = ALPHA_ONE >> 1;

    // Drop test widths: (raw + margin) << frac against average * 100
    localparam int DROP_W  = RAW_W + 1 + AVG_FRAC_BITS;
    localparam int X100_W  = AVG_W + 7;
    localparam int CMP_W   = (DROP_W > X100_W) ? DROP_W : X100_W;

    // Rounding of the average to a whole speed
    localparam int RND_W = AVG_W + 1;
    localparam logic [RND_W-1:0] ROUND_HALF = RND_W'((64'd1 << AVG_FRAC_BITS) >> 1);

    // Limits
    localparam logic [AVG_W-1:0]   AVG_MAX   = '1;
    localparam logic [SPEED_W-1:0] SPEED_MAX = '1;
    localparam logic [IDLE_W-1:0]  IDLE_MAX  = '1;
    localparam logic [LEN_W-1:0]   MIN_LEN   = LEN_W'(2);

    // Register reset values
    localparam logic [ALPHA_REG_W-1:0] ALPHA_RESET    = 16'd52429;
    localparam logic [ID_W-1:0]        FRAME_ID_RESET = 29'h631;
    localparam logic [RAW_W-1:0]       LOW_CUT_RESET  = 16'd500;
    localparam logic [RAW_W-1:0]       DROP_RESET     = 16'd1000;
    localparam logic [IDLE_W-1:0]      TIMEOUT_RESET  = 16'd1000;

    typedef enum logic {
        OP_FRAME = 1'b0,
        OP_TICK  = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHA    = 3'd0,
        CFG_FRAME_ID = 3'd1,
        CFG_LOW_CUT  = 3'd2,
        CFG_DROP     = 3'd3,
        CFG_TIMEOUT  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [ALPHA_REG_W-1:0] alpha;
        logic [ID_W-1:0]        frame_id;
        logic [RAW_W-1:0]       low_cut;
        logic [RAW_W-1:0]       drop_margin;
        logic [IDLE_W-1:0]      timeout_ms;
    } t_cfg;

    typedef struct packed {
        t_op               op;
        logic [ID_W-1:0]   frame_id;
        logic [LEN_W-1:0]  payload_len;
        logic [BYTE_W-1:0] byte_high;
        logic [BYTE_W-1:0] byte_low;
    } t_in_word;

    typedef struct packed {
        t_op                op;
        logic               match;
        logic [RAW_W-1:0]   raw;
        logic [RAWFX_W-1:0] rawfx;
    } t_stage_word;

endpackage
`default_nettype wire

>>> hdl/csef_regs.sv
// Configuration registers of the CAN speed EMA filter.
`default_nettype none
module csef_regs (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_valid,
    input  wire logic [csef_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [csef_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output csef_pkg::t_cfg                        o_cfg
);

    csef_pkg::t_cfg r_cfg;
    csef_pkg::t_cfg n_cfg;

    // Decode the write; unknown indexes leave everything as is
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (csef_pkg::t_cfg_idx'(i_cfg_index))
                csef_pkg::CFG_ALPHA: begin
                    n_cfg.alpha = i_cfg_data[csef_pkg::ALPHA_REG_W-1:0];
                end
                csef_pkg::CFG_FRAME_ID: begin
                    n_cfg.frame_id = i_cfg_data[csef_pkg::ID_W-1:0];
                end
                csef_pkg::CFG_LOW_CUT: begin
                    n_cfg.low_cut = i_cfg_data[csef_pkg::RAW_W-1:0];
                end
                csef_pkg::CFG_DROP: begin
                    n_cfg.drop_margin = i_cfg_data[csef_pkg::RAW_W-1:0];
                end
                csef_pkg::CFG_TIMEOUT: begin
                    n_cfg.timeout_ms = i_cfg_data[csef_pkg::IDLE_W-1:0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alpha       <= csef_pkg::ALPHA_RESET;
            r_cfg.frame_id    <= csef_pkg::FRAME_ID_RESET;
            r_cfg.low_cut     <= csef_pkg::LOW_CUT_RESET;
            r_cfg.drop_margin <= csef_pkg::DROP_RESET;
            r_cfg.timeout_ms  <= csef_pkg::TIMEOUT_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

>>> hdl/csef_front.sv
// Frame decode stage: identifier match, raw speed and its fixed-point form.
`default_nettype none
module csef_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_load,
    input  wire csef_pkg::t_in_word    i_word,
    input  wire csef_pkg::t_cfg        i_cfg,
    output csef_pkg::t_stage_word      o_word
);

    localparam int PRODX_W = csef_pkg::RAWX_W + csef_pkg::RECIP_W;

    csef_pkg::t_stage_word         r_word;
    csef_pkg::t_stage_word         n_word;
    logic [csef_pkg::RAW_W-1:0]    raw;
    logic [csef_pkg::RAWX_W-1:0]   rawx;
    logic [PRODX_W-1:0]            recip_prod;

    // Assemble the big-endian speed
    assign raw = {i_word.byte_high, i_word.byte_low};

    // Scale to the average format and divide by 100 through the reciprocal
    assign rawx = (csef_pkg::RAWX_W'(raw) << csef_pkg::AVG_FRAC_BITS)
                + csef_pkg::RAWX_W'(csef_pkg::RAW_ROUND);
    assign recip_prod = PRODX_W'(rawx) * PRODX_W'(csef_pkg::RECIP_MUL);

    always_comb begin
        n_word.op    = i_word.op;
        n_word.match = (i_word.frame_id == i_cfg.frame_id)
                    && (i_word.payload_len >= csef_pkg::MIN_LEN);
        n_word.raw   = raw;
        n_word.rawfx = recip_prod[csef_pkg::RECIP_SHIFT +: csef_pkg::RAWFX_W];
    end

    // Hold the decoded word for the update stage
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule
`default_nettype wire

>>> hdl/csef_update.sv
// Filter state update: idle counter, average blend and change-only speed output.
`default_nettype none
module csef_update (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_fire,
    input  wire csef_pkg::t_stage_word         i_word,
    input  wire csef_pkg::t_cfg                i_cfg,
    input  wire logic                          i_out_stall,
    output logic                               o_out_valid,
    output logic [csef_pkg::SPEED_W-1:0]       o_speed
);

    logic [csef_pkg::AVG_W-1:0]    r_average;
    logic [csef_pkg::AVG_W-1:0]    n_average;
    logic [csef_pkg::SPEED_W-1:0]  r_shown;
    logic [csef_pkg::SPEED_W-1:0]  n_shown;
    logic [csef_pkg::IDLE_W-1:0]   r_idle;
    logic [csef_pkg::IDLE_W-1:0]   n_idle;
    logic                          r_out_valid;
    logic                          n_out_valid;
    logic [csef_pkg::SPEED_W-1:0]  r_out_speed;

    logic [csef_pkg::IDLE_W-1:0]   idle_inc;
    logic [csef_pkg::A_W-1:0]      alpha_q;
    logic signed [csef_pkg::DIFF_W-1:0] avg_diff;
    logic signed [csef_pkg::PROD_W-1:0] blend_prod;
    logic [csef_pkg::SUM_W-1:0]    raw_shift;
    logic signed [csef_pkg::SUM_W-1:0]  blend_sum;
    logic [csef_pkg::Q_W-1:0]      blend_q;
    logic [csef_pkg::AVG_W-1:0]    blend_avg;
    logic [csef_pkg::AVG_W-1:0]    frame_avg;
    logic [csef_pkg::CMP_W-1:0]    drop_lhs;
    logic [csef_pkg::CMP_W-1:0]    avg_x100;
    logic                          low_hit;
    logic                          drop_hit;
    logic [csef_pkg::RND_W-1:0]    round_sum;
    logic [csef_pkg::RND_W-1:0]    round_val;
    logic [csef_pkg::SPEED_W-1:0]  new_speed;
    logic                          report;

    // Saturating idle count
    assign idle_inc = (r_idle == csef_pkg::IDLE_MAX) ? r_idle : r_idle + 1'b1;

    // Clamp the weight to one
    assign alpha_q = ({16'b0, i_cfg.alpha} > 32'(csef_pkg::ALPHA_ONE))
                   ? csef_pkg::ALPHA_ONE
                   : csef_pkg::A_W'(i_cfg.alpha);

    // Blend as raw + a * (avg - raw), a single multiply
    assign avg_diff = $signed({1'b0, (csef_pkg::DIFF_W-1)'(r_average)})
                    - $signed({1'b0, (csef_pkg::DIFF_W-1)'(i_word.rawfx)});
    assign blend_prod = $signed({1'b0, alpha_q}) * avg_diff;
    assign raw_shift  = csef_pkg::SUM_W'(i_word.rawfx) << csef_pkg::ALPHA_BITS;
    assign blend_sum  = $signed(raw_shift) + csef_pkg::SUM_W'(blend_prod)
                      + $signed(csef_pkg::SUM_W'(csef_pkg::ALPHA_HALF));
    assign blend_q    = blend_sum[csef_pkg::SUM_W-1:csef_pkg::ALPHA_BITS];
    assign blend_avg  = (blend_q > csef_pkg::Q_W'(csef_pkg::AVG_MAX))
                      ? csef_pkg::AVG_MAX
                      : blend_q[csef_pkg::AVG_W-1:0];

    // Low cut and exact drop test
    assign low_hit  = (i_word.raw <= i_cfg.low_cut);
    assign drop_lhs = (csef_pkg::CMP_W'(i_word.raw) + csef_pkg::CMP_W'(i_cfg.drop_margin))
                    << csef_pkg::AVG_FRAC_BITS;
    assign avg_x100 = csef_pkg::CMP_W'(r_average) * csef_pkg::CMP_W'(csef_pkg::RAW_SCALE);
    assign drop_hit = (drop_lhs < avg_x100);

    // Average after a matching frame
    assign frame_avg = (low_hit || drop_hit) ? '0 : blend_avg;

    // Round the updated average half up to a whole speed
    assign round_sum = csef_pkg::RND_W'(frame_avg) + csef_pkg::ROUND_HALF;
    assign round_val = round_sum >> csef_pkg::AVG_FRAC_BITS;

    // Next state and report decision
    always_comb begin
        n_average = r_average;
        n_idle    = r_idle;
        new_speed = r_shown;
        report    = 1'b0;
        if (i_word.op == csef_pkg::OP_TICK) begin
            n_idle = idle_inc;
            if (idle_inc > i_cfg.timeout_ms) begin
                n_average = '0;
                new_speed = '0;
                report    = (r_shown != '0);
            end
        end else if (i_word.match) begin
            n_idle    = '0;
            n_average = frame_avg;
            new_speed = (round_val > csef_pkg::RND_W'(csef_pkg::SPEED_MAX))
                      ? csef_pkg::SPEED_MAX
                      : round_val[csef_pkg::SPEED_W-1:0];
            report    = (new_speed != r_shown);
        end
        n_shown = report ? new_speed : r_shown;
    end

    // Output register: load on a report, drop when taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (i_fire) begin
            n_out_valid = report;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_average   <= '0;
            r_shown     <= '0;
            r_idle      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_fire) begin
                r_average <= n_average;
                r_shown   <= n_shown;
                r_idle    <= n_idle;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire && report) begin
            r_out_speed <= new_speed;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_speed     = r_out_speed;

endmodule
`default_nettype wire

>>> hdl/can_speed_ema_filter_top.sv
// Top level of the CAN speed EMA filter: handshakes, input register and stage control.
`default_nettype none
// Filters the speed carried in CAN frames with an exponential moving average
// and reports the rounded speed only when it changes. Each input word is either
// a received frame (operation 0) or a one-millisecond tick (operation 1); frames
// with a foreign identifier or fewer than two payload bytes are ignored, and a
// run of ticks past timeout_ms forces the speed to zero. The block takes one
// word per clock cycle for as long as the result side keeps up; a word passes
// through the input register, then the decode register, then the output
// register, and a word that changes nothing produces no result. The per-cycle
// limit is the state update stage, where the blend multiply, the drop test and
// the rounding of the new average all sit between the decode register and the
// filter state. The user must write the configuration registers through the cfg
// port only while no word is in flight; the block itself does not enforce this,
// and the port is always ready.
module can_speed_ema_filter_top (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // input word channel
    input  wire logic                             i_in_valid,
    output logic                                  o_in_stall,
    input  wire logic                             i_operation,
    input  wire logic [csef_pkg::ID_W-1:0]        i_frame_id,
    input  wire logic [csef_pkg::LEN_W-1:0]       i_payload_len,
    input  wire logic [csef_pkg::BYTE_W-1:0]      i_byte_high,
    input  wire logic [csef_pkg::BYTE_W-1:0]      i_byte_low,
    // result word channel
    output logic                                  o_out_valid,
    input  wire logic                             i_out_stall,
    output logic [csef_pkg::SPEED_W-1:0]          o_speed,
    // configuration write channel
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [csef_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [csef_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    csef_pkg::t_cfg        cfg;
    csef_pkg::t_in_word    r_s1;
    csef_pkg::t_stage_word s2_word;
    logic                  r_s1_valid;
    logic                  n_s1_valid;
    logic                  r_s2_valid;
    logic                  n_s2_valid;
    logic                  upd_fire;
    logic                  s2_load;
    logic                  s1_load;
    logic                  in_accept;

    assign o_cfg_ready = 1'b1;

    csef_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // Advance each stage when the one after it has room
    assign upd_fire   = r_s2_valid && (!o_out_valid || !i_out_stall);
    assign s2_load    = !r_s2_valid || upd_fire;
    assign s1_load    = !r_s1_valid || s2_load;
    assign o_in_stall = !s1_load;
    assign in_accept  = i_in_valid && s1_load;

    always_comb begin
        n_s1_valid = s1_load ? i_in_valid : r_s1_valid;
        n_s2_valid = s2_load ? r_s1_valid : r_s2_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
        end
    end

    // Capture the accepted word
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1.op          <= csef_pkg::t_op'(i_operation);
            r_s1.frame_id    <= i_frame_id;
            r_s1.payload_len <= i_payload_len;
            r_s1.byte_high   <= i_byte_high;
            r_s1.byte_low    <= i_byte_low;
        end
    end

    csef_front u_front (
        .i_clk  (i_clk),
        .i_load (s2_load && r_s1_valid),
        .i_word (r_s1),
        .i_cfg  (cfg),
        .o_word (s2_word)
    );

    csef_update u_update (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (upd_fire),
        .i_word      (s2_word),
        .i_cfg       (cfg),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_speed     (o_speed)
    );

endmodule
`default_nettype wire

>>> dv/can_speed_ema_filter_top_tb.sv
// Self-checking testbench of the CAN speed EMA filter: random traffic, stalls and a speed predictor.
`timescale 1ns / 100ps
module can_speed_ema_filter_top_tb;
    import csef_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 100000;

    typedef enum int {
        RX_FREE,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } t_rx_mode;

    // DUT ports
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_in_valid    = 1'b0;
    logic                  o_in_stall;
    logic                  i_operation   = 1'b0;
    logic [ID_W-1:0]       i_frame_id    = '0;
    logic [LEN_W-1:0]      i_payload_len = '0;
    logic [BYTE_W-1:0]     i_byte_high   = '0;
    logic [BYTE_W-1:0]     i_byte_low    = '0;
    logic                  o_out_valid;
    logic                  i_out_stall   = 1'b0;
    logic [SPEED_W-1:0]    o_speed;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    // Predicted register contents
    logic [ALPHA_REG_W-1:0] cfg_alpha    = ALPHA_RESET;
    logic [ID_W-1:0]        cfg_frame_id = FRAME_ID_RESET;
    logic [RAW_W-1:0]       cfg_low_cut  = LOW_CUT_RESET;
    logic [RAW_W-1:0]       cfg_drop     = DROP_RESET;
    logic [IDLE_W-1:0]      cfg_timeout  = TIMEOUT_RESET;

    // Predicted filter state
    logic [AVG_W-1:0]   ema_avg   = '0;
    logic [SPEED_W-1:0] ema_shown = '0;
    logic [IDLE_W-1:0]  idle_ms   = '0;

    logic [SPEED_W-1:0] speed_expected_q[$];

    int       err_cnt     = 0;
    int       cycle_cnt   = 0;
    int       burst_left  = 0;
    int       speed_level = 0;
    bit       gaps_on     = 1'b1;
    t_rx_mode rx_mode     = RX_FREE;

    can_speed_ema_filter_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_frame_id   (i_frame_id),
        .i_payload_len(i_payload_len),
        .i_byte_high  (i_byte_high),
        .i_byte_low   (i_byte_low),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_speed      (o_speed),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Count cycles and abort a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Stall the result side, switching between four patterns chosen at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (cycle_cnt % 64 == 0)
                rx_mode <= t_rx_mode'($urandom_range(0, 3));
            case (rx_mode)
                RX_FREE:  i_out_stall <= 1'b0;
                RX_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY: i_out_stall <= ($urandom_range(0, 3) != 0);
                default:  i_out_stall <= cycle_cnt[2];
            endcase
        end
    end

    // Compare each accepted result word with the oldest predicted speed
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (speed_expected_q.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected speed word, expected none, got %0d",
                         $time, o_speed);
            end else begin
                if (o_speed !== speed_expected_q[0]) begin
                    err_cnt++;
                    $display("%0t: speed mismatch, expected %0d, got %0d",
                             $time, speed_expected_q[0], o_speed);
                end
                void'(speed_expected_q.pop_front());
            end
        end
    end

    // Advance the predicted filter by one accepted word
    task automatic update_speed(input t_op op, input logic [ID_W-1:0] id,
                                input logic [LEN_W-1:0] len,
                                input logic [BYTE_W-1:0] bh, input logic [BYTE_W-1:0] bl);
        longint unsigned raw, rawfx, wgt, blend, avg64, rnd;
        if (op == OP_TICK) begin
            if (idle_ms != IDLE_MAX)
                idle_ms++;
            if (idle_ms > cfg_timeout) begin
                ema_avg = '0;
                if (ema_shown != '0) begin
                    ema_shown = '0;
                    speed_expected_q.push_back('0);
                end
            end
        end else if (id == cfg_frame_id && len >= MIN_LEN) begin
            idle_ms = '0;
            raw     = {bh, bl};
            avg64   = ema_avg;
            if (raw <= cfg_low_cut) begin
                ema_avg = '0;
            end else if (((raw + cfg_drop) << AVG_FRAC_BITS) < avg64 * RAW_SCALE) begin
                ema_avg = '0;
            end else begin
                rawfx = ((raw << AVG_FRAC_BITS) + RAW_ROUND) / RAW_SCALE;
                wgt   = cfg_alpha;
                if (wgt > (64'd1 << ALPHA_BITS))
                    wgt = 64'd1 << ALPHA_BITS;
                blend = (wgt * avg64 + ((64'd1 << ALPHA_BITS) - wgt) * rawfx
                         + (64'd1 << (ALPHA_BITS - 1))) >> ALPHA_BITS;
                ema_avg = (blend > AVG_MAX) ? AVG_MAX : blend[AVG_W-1:0];
            end
            rnd = (longint'(ema_avg) + (64'd1 << (AVG_FRAC_BITS - 1))) >> AVG_FRAC_BITS;
            if (rnd > SPEED_MAX)
                rnd = SPEED_MAX;
            if (rnd[SPEED_W-1:0] != ema_shown) begin
                ema_shown = rnd[SPEED_W-1:0];
                speed_expected_q.push_back(ema_shown);
            end
        end
    endtask

    // Send one input word in bursts with random gaps between them
    task automatic send_word(input t_op op, input logic [ID_W-1:0] id,
                             input logic [LEN_W-1:0] len,
                             input logic [BYTE_W-1:0] bh, input logic [BYTE_W-1:0] bl);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = gaps_on ? $urandom_range(0, 5) : 0;
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_in_valid    <= 1'b1;
        i_operation   <= op;
        i_frame_id    <= id;
        i_payload_len <= len;
        i_byte_high   <= bh;
        i_byte_low    <= bl;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        update_speed(op, id, len, bh, bl);
    endtask

    task automatic send_frame(input logic [ID_W-1:0] id, input logic [LEN_W-1:0] len,
                              input logic [RAW_W-1:0] raw);
        send_word(OP_FRAME, id, len, raw[15:8], raw[7:0]);
    endtask

    // Ticks carry random frame fields, which the block must disregard
    task automatic send_tick();
        send_word(OP_TICK, ID_W'($urandom), LEN_W'($urandom),
                  BYTE_W'($urandom), BYTE_W'($urandom));
    endtask

    // Hold the input until every predicted speed has arrived, then let the pipe drain
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (speed_expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one register; unused data bits are filled with noise
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        logic [CFG_DATA_W-1:0] keep;
        logic [CFG_DATA_W-1:0] data;
        keep = (idx == CFG_FRAME_ID) ? '1 : CFG_DATA_W'(16'hFFFF);
        data = (val & keep) | (CFG_DATA_W'($urandom) & ~keep);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_ALPHA:    cfg_alpha    = data[ALPHA_REG_W-1:0];
            CFG_FRAME_ID: cfg_frame_id = data[ID_W-1:0];
            CFG_LOW_CUT:  cfg_low_cut  = data[RAW_W-1:0];
            CFG_DROP:     cfg_drop     = data[RAW_W-1:0];
            CFG_TIMEOUT:  cfg_timeout  = data[IDLE_W-1:0];
            default:      ;
        endcase
    endtask

    task automatic program_filter(input logic [ALPHA_REG_W-1:0] alpha,
                                  input logic [ID_W-1:0] id,
                                  input logic [RAW_W-1:0] low_cut,
                                  input logic [RAW_W-1:0] drop,
                                  input logic [IDLE_W-1:0] timeout);
        wait_idle();
        write_reg(CFG_ALPHA,    CFG_DATA_W'(alpha));
        write_reg(CFG_FRAME_ID, CFG_DATA_W'(id));
        write_reg(CFG_LOW_CUT,  CFG_DATA_W'(low_cut));
        write_reg(CFG_DROP,     CFG_DATA_W'(drop));
        write_reg(CFG_TIMEOUT,  CFG_DATA_W'(timeout));
        i_cfg_valid <= 1'b0;
    endtask

    // Next raw speed: mostly a random walk, sometimes a cut, a drop or a jump
    function automatic logic [RAW_W-1:0] next_raw();
        int step;
        case ($urandom_range(0, 9))
            0:       speed_level = $urandom_range(0, int'(cfg_low_cut));
            1:       speed_level = speed_level / 3;
            2:       speed_level = $urandom_range(0, 65535);
            default: begin
                step        = int'($urandom_range(0, 600)) - 300;
                speed_level = speed_level + step;
            end
        endcase
        if (speed_level < 0)
            speed_level = 0;
        if (speed_level > 65535)
            speed_level = 65535;
        return RAW_W'(speed_level);
    endfunction

    // Reset values: blend, short and foreign frames, low cut at equality, idle ticks
    task automatic test_reset_values();
        send_frame(FRAME_ID_RESET, LEN_W'(2), 16'd5000);
        send_frame(FRAME_ID_RESET, LEN_W'(8), 16'd5200);
        send_frame(FRAME_ID_RESET, LEN_W'(1), 16'd9000);
        send_frame(FRAME_ID_RESET ^ ID_W'(1), LEN_W'(2), 16'd9000);
        send_frame(FRAME_ID_RESET, LEN_W'(3), 16'd3000);
        send_frame(FRAME_ID_RESET, LEN_W'(2), 16'd500);
        send_frame(FRAME_ID_RESET, LEN_W'(2), 16'd501);
        send_frame(FRAME_ID_RESET, LEN_W'(2), 16'd6000);
        repeat (4) send_tick();
    endtask

    // Field extremes, long payloads, repeated timeout, low cut and drop clears
    task automatic test_field_extremes();
        program_filter(16'd32768, '1, '0, '1, 16'd2);
        send_frame('1, LEN_W'(2),  16'hFFFF);
        send_frame('1, LEN_W'(15), 16'hFFFF);
        send_frame('1, LEN_W'(8),  16'h0000);
        send_frame('1, LEN_W'(9),  16'h0001);
        send_frame('1, LEN_W'(4),  16'hAA55);
        send_frame('1, LEN_W'(5),  16'h55AA);
        send_frame('0, LEN_W'(2),  16'h5555);
        send_frame('1, LEN_W'(0),  16'h1234);
        send_frame('1, LEN_W'(1),  16'h4321);
        repeat (5) send_tick();
        send_frame('1, LEN_W'(2), 16'd20000);
        send_frame('1, LEN_W'(2), 16'd20000);
        program_filter(cfg_alpha, cfg_frame_id, '1, cfg_drop, cfg_timeout);
        send_frame('1, LEN_W'(2), 16'hFFFF);
        program_filter(cfg_alpha, cfg_frame_id, 16'd100, '0, cfg_timeout);
        send_frame('1, LEN_W'(2), 16'd20000);
        send_frame('1, LEN_W'(2), 16'd20000);
        send_frame('1, LEN_W'(2), 16'd10000);
    endtask

    // Weight extremes and a zero timeout
    task automatic test_weight_extremes();
        program_filter('0, FRAME_ID_RESET, LOW_CUT_RESET, DROP_RESET, '0);
        send_frame(FRAME_ID_RESET, LEN_W'(2), 16'd12345);
        send_frame(FRAME_ID_RESET, LEN_W'(2), 16'd12000);
        send_tick();
        program_filter('1, FRAME_ID_RESET, LOW_CUT_RESET, DROP_RESET, 16'd3);
        send_frame(FRAME_ID_RESET, LEN_W'(2), 16'd40000);
        send_frame(FRAME_ID_RESET, LEN_W'(2), 16'd40000);
        send_frame(FRAME_ID_RESET, LEN_W'(2), 16'hFFFF);
    endtask

    // Writes to unused register indexes must leave the filter unchanged
    task automatic test_unused_registers();
        wait_idle();
        for (int idx = int'(CFG_TIMEOUT) + 1; idx < (1 << CFG_IDX_W); idx++)
            write_reg(CFG_IDX_W'(idx), CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
        send_frame(cfg_frame_id, LEN_W'(2), 16'd7000);
        send_frame(cfg_frame_id, LEN_W'(6), 16'd7100);
        send_tick();
    endtask

    // Largest timeouts: a run of back-to-back ticks leaves the speed in place
    task automatic test_idle_saturation();
        program_filter(16'd40000, FRAME_ID_RESET, LOW_CUT_RESET, DROP_RESET, IDLE_MAX);
        gaps_on = 1'b0;
        send_frame(FRAME_ID_RESET, LEN_W'(2), 16'd30000);
        repeat (20) send_tick();
        gaps_on = 1'b1;
        program_filter(cfg_alpha, cfg_frame_id, cfg_low_cut, cfg_drop, IDLE_MAX - IDLE_W'(1));
        send_tick();
    endtask

    // Random traffic over several register settings, extremes first
    task automatic test_random_traffic();
        int phase, counted, pick, run;
        logic [ID_W-1:0] other_id;
        for (phase = 0; phase < 5; phase++) begin
            case (phase)
                0:       program_filter('0, '0, '0, '0, '0);
                1:       program_filter('1, '1, RAW_W'($urandom_range(0, 3000)), '1, '1);
                default: program_filter(ALPHA_REG_W'($urandom), ID_W'($urandom),
                                        RAW_W'($urandom_range(0, 3000)),
                                        RAW_W'($urandom_range(0, 4000)),
                                        IDLE_W'($urandom_range(1, 30)));
            endcase
            speed_level = $urandom_range(1000, 20000);
            counted     = 0;
            while (counted < 70) begin
                pick = $urandom_range(0, 99);
                if (pick < 55) begin
                    send_frame(cfg_frame_id, LEN_W'($urandom_range(2, 8)), next_raw());
                    counted++;
                end else if (pick < 78) begin
                    send_tick();
                    counted++;
                end else if (pick < 84) begin
                    // for a timeout up to 40, run past it so the speed is forced to zero
                    run = (cfg_timeout > 40) ? 3 : int'(cfg_timeout) + $urandom_range(1, 3);
                    repeat (run) send_tick();
                    counted += run;
                end else if (pick < 90) begin
                    other_id = ID_W'($urandom);
                    if (other_id == cfg_frame_id)
                        other_id ^= ID_W'(1);
                    send_frame(other_id, LEN_W'($urandom), RAW_W'($urandom));
                end else if (pick < 95) begin
                    send_frame(cfg_frame_id, LEN_W'($urandom_range(0, 1)), RAW_W'($urandom));
                end else begin
                    send_frame(cfg_frame_id, LEN_W'($urandom_range(9, 15)), next_raw());
                    counted++;
                end
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_values();
        test_field_extremes();
        test_weight_extremes();
        test_unused_registers();
        test_idle_saturation();
        test_random_traffic();
        wait_idle();
        if (err_cnt == 0 && speed_expected_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/csef_pkg.sv
hdl/csef_regs.sv
hdl/csef_front.sv
hdl/csef_update.sv
hdl/can_speed_ema_filter_top.sv
dv/can_speed_ema_filter_top_tb.sv
